@@ design/ram_window_bank_mapper_unit_macros.svh @@
// Assertion macros used by the window bank mapper top level
`ifndef RAM_WINDOW_BANK_MAPPER_UNIT_MACROS_SVH
`define RAM_WINDOW_BANK_MAPPER_UNIT_MACROS_SVH

// Clocked check, masked while reset is held
`define RWBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define RWBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rwbm_pkg.sv @@
// Shared types and constants of the window bank mapper
package rwbm_pkg;

    localparam int unsigned NUM_WINDOWS    = 4;
    localparam int unsigned WIN_W          = 2;
    localparam int unsigned BANK_SEL_W     = 4;
    localparam int unsigned DATA_W         = 8;
    localparam int unsigned ADDR_W         = 16;
    localparam int unsigned OFF_W          = 14;
    localparam int unsigned BOOT_ROM_BYTES = 4096;

    // First address past the boot ROM, as a full-width address
    localparam logic [ADDR_W-1:0] BOOT_END = ADDR_W'(BOOT_ROM_BYTES);

    typedef enum logic [1:0] {
        KIND_SELECT  = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_BOOT    = 2'd2,
        KIND_LOOKUP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ROUTE_RAM      = 2'd0,
        ROUTE_UNMAPPED = 2'd1,
        ROUTE_BOOT     = 2'd2,
        ROUTE_WRITE_OK = 2'd3
    } route_t;

    typedef enum logic [1:0] {
        VIEW_RAM      = 2'd0,
        VIEW_UNMAPPED = 2'd1,
        VIEW_BOOT     = 2'd2
    } view_t;

    typedef struct packed {
        logic [NUM_WINDOWS-1:0]            bank_enabled;
        logic [NUM_WINDOWS-1:0][WIN_W-1:0] window_bank;
        logic [NUM_WINDOWS-1:0][1:0]       window_view;
    } map_state_t;

endpackage

@@ design/rwbm_map_regs.sv @@
// Mapping registers: bank select latch, bank enables, window banks and views
module rwbm_map_regs
    import rwbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd_en,
    input  logic [1:0]        kind,
    input  logic [DATA_W-1:0] data_byte,
    output map_state_t        map_state
);

    logic [BANK_SEL_W-1:0]             latch_reg, latch_next;
    logic [NUM_WINDOWS-1:0]            en_reg, en_next;
    logic [NUM_WINDOWS-1:0][WIN_W-1:0] wb_reg, wb_next;
    logic [NUM_WINDOWS-1:0][1:0]       view_reg, view_next;

    logic [WIN_W-1:0] bank;
    logic [WIN_W-1:0] win;
    logic             bank_ok;
    logic             accept;
    logic             enable;

    assign bank    = latch_reg[WIN_W-1:0];
    assign bank_ok = (latch_reg[BANK_SEL_W-1:WIN_W] == '0);
    assign win     = data_byte[WIN_W-1:0];
    assign accept  = data_byte[2];
    assign enable  = data_byte[3];

    // Decode the write and form the next map
    always_comb
    begin
        latch_next = latch_reg;
        en_next    = en_reg;
        wb_next    = wb_reg;
        view_next  = view_reg;
        if (upd_en)
        begin
            unique case (kind_t'(kind))
                KIND_SELECT:
                begin
                    latch_next = data_byte[BANK_SEL_W-1:0];
                end
                KIND_PROGRAM:
                begin
                    if (bank_ok)
                    begin
                        en_next[bank] = enable;
                        if (accept)
                        begin
                            wb_next[win] = bank;
                        end
                        // retarget every non-boot window that now shows this bank
                        for (int i = 0; i < NUM_WINDOWS; i++)
                        begin
                            if (wb_next[i] == bank && view_reg[i] != VIEW_BOOT)
                            begin
                                view_next[i] = enable ? VIEW_RAM : VIEW_UNMAPPED;
                            end
                        end
                    end
                    else if (accept)
                    begin
                        view_next[win] = VIEW_UNMAPPED;
                    end
                end
                KIND_BOOT:
                begin
                    if (data_byte[0])
                    begin
                        view_next[0] = VIEW_BOOT;
                    end
                    else
                    begin
                        view_next[0] = en_reg[0] ? VIEW_RAM : VIEW_UNMAPPED;
                    end
                end
                KIND_LOOKUP:
                begin
                end
            endcase
        end
    end

    // Hold the map; window 0 comes up showing the boot ROM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
            en_reg    <= '0;
            wb_reg    <= '0;
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                view_reg[i] <= VIEW_UNMAPPED;
            end
            view_reg[0] <= VIEW_BOOT;
        end
        else
        begin
            latch_reg <= latch_next;
            en_reg    <= en_next;
            wb_reg    <= wb_next;
            view_reg  <= view_next;
        end
    end

    assign map_state.bank_enabled = en_reg;
    assign map_state.window_bank  = wb_reg;
    assign map_state.window_view  = view_reg;

endmodule

@@ design/rwbm_xlate.sv @@
// Address translation: route and physical address for one item
module rwbm_xlate
    import rwbm_pkg::*;
#(
    parameter int unsigned BOOT_BYTES = BOOT_ROM_BYTES
)
(
    input  map_state_t        map_state,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] cpu_address,
    output logic [1:0]        route,
    output logic [ADDR_W-1:0] physical_address
);

    // First address past the boot ROM, as a full-width address
    localparam logic [ADDR_W-1:0] BOOT_LIMIT = ADDR_W'(BOOT_BYTES);

    logic [WIN_W-1:0] win;
    logic [OFF_W-1:0] off;
    logic [1:0]       view;

    assign win  = cpu_address[ADDR_W-1:OFF_W];
    assign off  = cpu_address[OFF_W-1:0];
    assign view = map_state.window_view[win];

    // Pick the route from the window's view; non-lookup items get the write-OK route
    always_comb
    begin
        route            = ROUTE_WRITE_OK;
        physical_address = '0;
        if (kind_t'(kind) == KIND_LOOKUP)
        begin
            case (view)
                VIEW_RAM:
                begin
                    route            = ROUTE_RAM;
                    physical_address = {map_state.window_bank[win], off};
                end
                VIEW_BOOT:
                begin
                    if ({{(ADDR_W-OFF_W){1'b0}}, off} < BOOT_LIMIT)
                    begin
                        route            = ROUTE_BOOT;
                        physical_address = {{(ADDR_W-OFF_W){1'b0}}, off};
                    end
                    else
                    begin
                        route = ROUTE_UNMAPPED;
                    end
                end
                default:
                begin
                    route = ROUTE_UNMAPPED;
                end
            endcase
        end
    end

endmodule

@@ design/ram_window_bank_mapper_unit.sv @@
// Top level of the window bank mapper: input register, map, translation, result register
//
// Maps the four 16 KB processor windows onto four 16 KB RAM banks, with the
// boot ROM overlaid on window 0 after reset. Each transfer on the input side
// is a register write or an address lookup and yields exactly one result
// transfer, in order. One item is taken every clock cycle while in_stall is
// low; each item is held in the input register and then its result is held
// in the result register, from which it transfers.
// Register writes take effect as the item moves from the input register to
// the result register, so a lookup right after a write already sees the new
// mapping. A stalled result holds the result register; the input register
// still takes one more item, and the input side stalls once that item waits.
`include "ram_window_bank_mapper_unit_macros.svh"

module ram_window_bank_mapper_unit
    import rwbm_pkg::*;
#(
    parameter int unsigned BOOT_BYTES = BOOT_ROM_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [DATA_W-1:0] data_byte,
    input  logic [ADDR_W-1:0] cpu_address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        route,
    output logic [ADDR_W-1:0] physical_address
);

    // First address past the boot ROM, as a full-width address
    localparam logic [ADDR_W-1:0] BOOT_LIMIT = ADDR_W'(BOOT_BYTES);

    logic              s1_valid_reg;
    logic [1:0]        s1_kind_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic              out_valid_reg;
    logic [1:0]        route_reg;
    logic [ADDR_W-1:0] phys_reg;

    logic              s1_advance;
    logic              in_fire;
    logic              s1_fire;
    map_state_t        map_state;
    logic [1:0]        route_next;
    logic [ADDR_W-1:0] phys_next;

    // Advance when the result register is empty or being drained
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_fire    = in_valid && !in_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;

    // Input register control: load whenever the input side is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= kind;
            s1_data_reg <= data_byte;
            s1_addr_reg <= cpu_address;
        end
    end

    rwbm_map_regs u_map_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_en    (s1_fire),
        .kind      (s1_kind_reg),
        .data_byte (s1_data_reg),
        .map_state (map_state)
    );

    rwbm_xlate #(
        .BOOT_BYTES (BOOT_BYTES)
    ) u_xlate (
        .map_state        (map_state),
        .kind             (s1_kind_reg),
        .cpu_address      (s1_addr_reg),
        .route            (route_next),
        .physical_address (phys_next)
    );

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            route_reg <= route_next;
            phys_reg  <= phys_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign route            = route_reg;
    assign physical_address = phys_reg;

    `RWBM_ASSERT(a_write_addr_zero,
        out_valid_reg && route_reg == ROUTE_WRITE_OK |-> phys_reg == '0,
        "write result carries an address")
    `RWBM_ASSERT(a_boot_in_rom,
        out_valid_reg && route_reg == ROUTE_BOOT |-> phys_reg < BOOT_LIMIT,
        "boot route past the ROM")
    `RWBM_ASSERT(a_s1_hold,
        s1_valid_reg && !s1_advance |=> s1_valid_reg,
        "stalled input item lost")
    `RWBM_ASSERT(a_result_source,
        $rose(out_valid_reg) |-> $past(s1_valid_reg),
        "result without a queued item")
    `RWBM_ASSERT_ALWAYS(a_boot_window0,
        map_state.window_view[1] != VIEW_BOOT && map_state.window_view[2] != VIEW_BOOT
            && map_state.window_view[3] != VIEW_BOOT,
        "boot view outside window 0")

endmodule
